/* hdl/rac_pkg.sv */
// Shared types and codes for the request/ACK token correlator.
// Holds the action and status codes and the item/result records.
// No dependencies; compiled first.
package rac_pkg;

  localparam int unsigned TokenW = 16;
  localparam int unsigned IssueW = TokenW + 1;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned ReqW   = 2;

  typedef enum logic [2:0] {
    ACT_BEGIN         = 3'd0,
    ACT_ARM           = 3'd1,
    ACT_ACK           = 3'd2,
    ACT_TIMEOUT       = 3'd3,
    ACT_CHECK         = 3'd4,
    ACT_SESSION_RESET = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_NO_ACK    = 3'd4,
    ST_IGNORED   = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [ReqW-1:0]   instance_req;
    logic [DataW-1:0]  data;
    logic [TokenW-1:0] ack_seq;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [TokenW-1:0] token;
    logic              ack_accepted;
    logic [DataW-1:0]  payload;
    logic [CountW-1:0] ignored_count;
  } result_t;

endpackage

/* hdl/rac_in_stage.sv */
// Input register of the correlator: captures one transaction per cycle while not stalled.
// Depends on rac_pkg.
module rac_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rac_pkg::item_t item_i,
  input  logic           fire_i,
  output logic           valid_o,
  output rac_pkg::item_t item_o
);
  import rac_pkg::*;

  logic  valid_q, valid_d;
  logic  accept;
  item_t item_q;

  // A held item blocks the input unless it moves on this cycle.
  assign in_stall_o = valid_q && !fire_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/rac_table.sv */
// Per-instance correlation records and the single-pass action logic.
// Read-modify-write of one record per fired transaction (all records on a session reset). Depends on rac_pkg.
module rac_table #(
  parameter int unsigned INSTANCES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  rac_pkg::item_t   item_i,
  output rac_pkg::result_t result_o
);
  import rac_pkg::*;

  localparam int unsigned IdxW = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int unsigned ExtW = IdxW + ReqW;

  logic              armed_q [INSTANCES];
  logic              armed_d [INSTANCES];
  logic [TokenW-1:0] wait_tok_q [INSTANCES];
  logic [TokenW-1:0] wait_tok_d [INSTANCES];
  logic [IssueW-1:0] next_iss_q [INSTANCES];
  logic [IssueW-1:0] next_iss_d [INSTANCES];
  logic [DataW-1:0]  held_q [INSTANCES];
  logic [DataW-1:0]  held_d [INSTANCES];
  logic [CountW-1:0] stale_q [INSTANCES];
  logic [CountW-1:0] stale_d [INSTANCES];
  logic              pend_q [INSTANCES];
  logic              pend_d [INSTANCES];

  logic [ExtW-1:0] req_ext;
  logic [IdxW-1:0] sel;
  logic            inst_ok;
  result_t         res;

  assign req_ext = {{IdxW{1'b0}}, item_i.instance_req};
  assign sel     = req_ext[IdxW-1:0];
  assign inst_ok = req_ext < ExtW'(INSTANCES);

  always_comb begin
    for (int j = 0; j < INSTANCES; j++) begin
      armed_d[j]    = armed_q[j];
      wait_tok_d[j] = wait_tok_q[j];
      next_iss_d[j] = next_iss_q[j];
      held_d[j]     = held_q[j];
      stale_d[j]    = stale_q[j];
      pend_d[j]     = pend_q[j];
    end
    res = '0;
    res.status = ST_OK;

    if (item_i.action == ACT_SESSION_RESET) begin
      // stale counters survive a session reset
      for (int j = 0; j < INSTANCES; j++) begin
        armed_d[j]    = 1'b0;
        wait_tok_d[j] = '0;
        held_d[j]     = '0;
        pend_d[j]     = 1'b0;
        next_iss_d[j] = IssueW'(1);
      end
    end else if (inst_ok) begin
      case (item_i.action)
        ACT_BEGIN: begin
          armed_d[sel]    = 1'b0;
          wait_tok_d[sel] = '0;
          held_d[sel]     = '0;
          pend_d[sel]     = 1'b0;
        end
        ACT_ARM: begin
          // token space ends at all-ones; the extra bit marks exhaustion
          if (next_iss_q[sel][IssueW-1]) begin
            res.status = ST_EXHAUSTED;
          end else begin
            res.token       = next_iss_q[sel][TokenW-1:0];
            next_iss_d[sel] = next_iss_q[sel] + IssueW'(1);
            wait_tok_d[sel] = next_iss_q[sel][TokenW-1:0];
            held_d[sel]     = '0;
            armed_d[sel]    = 1'b1;
          end
        end
        ACT_ACK: begin
          if (armed_q[sel] && (item_i.ack_seq == wait_tok_q[sel])) begin
            held_d[sel]      = item_i.data;
            armed_d[sel]     = 1'b0;
            wait_tok_d[sel]  = '0;
            pend_d[sel]      = 1'b1;
            res.ack_accepted = 1'b1;
          end else begin
            stale_d[sel] = stale_q[sel] + CountW'(1);
            res.status   = ST_IGNORED;
          end
        end
        ACT_TIMEOUT: begin
          armed_d[sel]    = 1'b0;
          wait_tok_d[sel] = '0;
          held_d[sel]     = '0;
          res.status      = ST_TIMEOUT;
        end
        ACT_CHECK: begin
          if (!pend_q[sel]) begin
            res.status = ST_NO_ACK;
          end else begin
            pend_d[sel] = 1'b0;
            res.status  = (held_q[sel] == item_i.data) ? ST_OK : ST_MISMATCH;
          end
        end
        default: begin
        end
      endcase
    end

    if (inst_ok) begin
      res.payload       = held_d[sel];
      res.ignored_count = stale_d[sel];
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < INSTANCES; j++) begin
        armed_q[j]    <= 1'b0;
        wait_tok_q[j] <= '0;
        next_iss_q[j] <= IssueW'(1);
        held_q[j]     <= '0;
        stale_q[j]    <= '0;
        pend_q[j]     <= 1'b0;
      end
    end else if (fire_i) begin
      for (int j = 0; j < INSTANCES; j++) begin
        armed_q[j]    <= armed_d[j];
        wait_tok_q[j] <= wait_tok_d[j];
        next_iss_q[j] <= next_iss_d[j];
        held_q[j]     <= held_d[j];
        stale_q[j]    <= stale_d[j];
        pend_q[j]     <= pend_d[j];
      end
    end
  end

  assign result_o = res;

endmodule

/* hdl/rac_out_stage.sv */
// Result register of the correlator with the output handshake.
// Depends on rac_pkg.
module rac_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             src_valid_i,
  output logic             fire_o,
  input  rac_pkg::result_t result_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rac_pkg::result_t result_o
);
  import rac_pkg::*;

  logic    valid_q, valid_d;
  logic    room;
  result_t res_q;

  assign room   = !valid_q || !out_stall_i;
  assign fire_o = src_valid_i && room;

  always_comb begin
    valid_d = valid_q;
    if (room) begin
      valid_d = src_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

/* hdl/request_ack_token_correlator_unit.sv */
// Request/ACK token correlator, top level.
// Uses the input stage, the record table and the result stage; depends on rac_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one action per transaction:
//   begin, arm, ack received, timeout, check or session reset, aimed at one
//   correlation instance. Output channel (out_valid_o / out_stall_i) returns
//   exactly one result per input transaction, in order.
//   Path: from input acceptance to result valid the item goes through the input register,
//   then one pass through the instance record into the result register.
//   Throughput: one transaction per cycle while out_stall_i is low; each action is a single
//   read-modify-write of one instance record (all records on a session reset), finished in that one pass.
//   Reset: all instances are disarmed, payloads and stale counters cleared,
//   and every token counter set to 1. Both registers come up empty.
//   Stall: while a result waits in the result register, one more transaction
//   is still taken into the input register; after that in_stall_o rises until
//   the receiver drops out_stall_i. Nothing is lost or repeated.
module request_ack_token_correlator_unit #(
  parameter int unsigned INSTANCES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [1:0]  instance_req_i,
  input  logic [31:0] data_i,
  input  logic [15:0] ack_seq_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] token_o,
  output logic        ack_accepted_o,
  output logic [31:0] payload_o,
  output logic [31:0] ignored_count_o
);
  import rac_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    fire;
  result_t step_res;
  result_t out_res;

  assign in_item.action       = action_i;
  assign in_item.instance_req = instance_req_i;
  assign in_item.data         = data_i;
  assign in_item.ack_seq      = ack_seq_i;

  rac_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .fire_i     (fire),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  rac_table #(
    .INSTANCES (INSTANCES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .result_o (step_res)
  );

  rac_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (held_valid),
    .fire_o      (fire),
    .result_i    (step_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign status_o        = out_res.status;
  assign token_o         = out_res.token;
  assign ack_accepted_o  = out_res.ack_accepted;
  assign payload_o       = out_res.payload;
  assign ignored_count_o = out_res.ignored_count;

endmodule

/* sim/tb_request_ack_token_correlator_unit.sv */
// Testbench for request_ack_token_correlator_unit: directed and random runs,
// with a scoreboard class that predicts one result per accepted transaction.
// Depends on rac_pkg and the correlator RTL.
`timescale 1ns / 1ps

module tb_request_ack_token_correlator_unit;
  import rac_pkg::*;

  localparam int unsigned NINST       = 4;
  localparam logic [16:0] TOKEN_LAST  = 17'h0FFFF;
  localparam logic [2:0]  ACT_SPARE_6 = 3'd6;
  localparam logic [2:0]  ACT_SPARE_7 = 3'd7;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          HANG_LIMIT   = 4000;

  class corr_ledger;
    logic        armed    [NINST];
    logic [15:0] wait_tok [NINST];
    logic [16:0] next_tok [NINST];
    logic [31:0] held     [NINST];
    logic [31:0] stale    [NINST];
    logic        pending  [NINST];
    result_t     due_results[$];
    int unsigned errors;
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned status_hits [8];

    function void power_on();
      for (int j = 0; j < NINST; j++) begin
        armed[j]    = 1'b0;
        wait_tok[j] = '0;
        next_tok[j] = 17'd1;
        held[j]     = '0;
        stale[j]    = '0;
        pending[j]  = 1'b0;
      end
      for (int j = 0; j < 8; j++) status_hits[j] = 0;
      errors    = 0;
      n_items   = 0;
      n_checked = 0;
    endfunction

    // Update the instance records for one accepted transaction and queue its result.
    function void log_request(item_t it);
      result_t exp;
      int k;
      k = int'(it.instance_req);
      exp = '0;
      exp.status = ST_OK;
      if (it.action == ACT_SESSION_RESET) begin
        for (int j = 0; j < NINST; j++) begin
          armed[j]    = 1'b0;
          wait_tok[j] = '0;
          held[j]     = '0;
          pending[j]  = 1'b0;
          next_tok[j] = 17'd1;
        end
      end else begin
        case (it.action)
          ACT_BEGIN: begin
            armed[k]    = 1'b0;
            wait_tok[k] = '0;
            held[k]     = '0;
            pending[k]  = 1'b0;
          end
          ACT_ARM: begin
            if (next_tok[k] > TOKEN_LAST) begin
              exp.status = ST_EXHAUSTED;
            end else begin
              exp.token   = next_tok[k][15:0];
              next_tok[k] = next_tok[k] + 17'd1;
              wait_tok[k] = exp.token;
              held[k]     = '0;
              armed[k]    = 1'b1;
            end
          end
          ACT_ACK: begin
            if (armed[k] && it.ack_seq == wait_tok[k]) begin
              held[k]          = it.data;
              armed[k]         = 1'b0;
              wait_tok[k]      = '0;
              pending[k]       = 1'b1;
              exp.ack_accepted = 1'b1;
            end else begin
              stale[k]   = stale[k] + 32'd1;
              exp.status = ST_IGNORED;
            end
          end
          ACT_TIMEOUT: begin
            armed[k]    = 1'b0;
            wait_tok[k] = '0;
            held[k]     = '0;
            exp.status  = ST_TIMEOUT;
          end
          ACT_CHECK: begin
            if (!pending[k]) begin
              exp.status = ST_NO_ACK;
            end else begin
              pending[k] = 1'b0;
              exp.status = (held[k] == it.data) ? ST_OK : ST_MISMATCH;
            end
          end
          default: ;  // spare codes leave every record alone
        endcase
      end
      exp.payload       = held[k];
      exp.ignored_count = stale[k];
      status_hits[exp.status]++;
      n_items++;
      due_results.push_back(exp);
    endfunction

    function void cmp_field(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp, got);
      end
    endfunction

    function void match_result(result_t got);
      result_t exp;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        return;
      end
      exp = due_results.pop_front();
      n_checked++;
      cmp_field("status", 32'(exp.status), 32'(got.status));
      cmp_field("token", 32'(exp.token), 32'(got.token));
      cmp_field("ack_accepted", 32'(exp.ack_accepted), 32'(got.ack_accepted));
      cmp_field("payload", exp.payload, got.payload);
      cmp_field("ignored_count", exp.ignored_count, got.ignored_count);
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i       = '0;
  logic [1:0]  instance_req_i = '0;
  logic [31:0] data_i         = '0;
  logic [15:0] ack_seq_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] token_o;
  logic        ack_accepted_o;
  logic [31:0] payload_o;
  logic [31:0] ignored_count_o;

  corr_ledger ledger;
  bit         calm = 1'b0;  // no idling on either side while set
  int         stall_left = 0;
  int         dead_cycles = 0;

  request_ack_token_correlator_unit #(.INSTANCES(NINST)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .instance_req_i  (instance_req_i),
    .data_i          (data_i),
    .ack_seq_i       (ack_seq_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .token_o         (token_o),
    .ack_accepted_o  (ack_accepted_o),
    .payload_o       (payload_o),
    .ignored_count_o (ignored_count_o)
  );

  always #6 clk_i = ~clk_i;

  // mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t mk(logic [2:0] act, logic [1:0] slot, logic [31:0] d,
                               logic [15:0] seq);
    item_t it;
    it.action       = act;
    it.instance_req = slot;
    it.data         = d;
    it.ack_seq      = seq;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the transaction.
  task automatic send_item(item_t it);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.action;
    instance_req_i <= it.instance_req;
    data_i         <= it.data;
    ack_seq_i      <= it.ack_seq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.log_request(it);
  endtask

  // begin / arm / ack / check with the odd detour thrown in
  task automatic run_exchange(logic [1:0] k);
    logic [15:0] seq;
    logic [31:0] d;
    if ($urandom_range(0, 1) == 1) send_item(mk(ACT_BEGIN, k, $urandom, 16'($urandom)));
    send_item(mk(ACT_ARM, k, $urandom, 16'($urandom)));
    case ($urandom_range(0, 9))
      0: send_item(mk(ACT_TIMEOUT, k, $urandom, 16'($urandom)));
      1: send_item(mk(ACT_ACK, k, $urandom, ledger.wait_tok[k] + 16'd1));
      2: send_item(mk(ACT_ARM, k, $urandom, 16'($urandom)));
      default: ;
    endcase
    seq = ($urandom_range(0, 7) != 0) ? ledger.wait_tok[k] : 16'($urandom);
    send_item(mk(ACT_ACK, k, $urandom, seq));
    if ($urandom_range(0, 3) != 0) begin
      d = ($urandom_range(0, 3) != 0) ? ledger.held[k] : $urandom;
      send_item(mk(ACT_CHECK, k, d, 16'($urandom)));
    end
  endtask

  task automatic send_noise();
    logic [1:0]  k;
    logic [15:0] seq;
    k = 2'($urandom_range(0, NINST - 1));
    case ($urandom_range(0, 2))
      0:       seq = ledger.wait_tok[k];
      1:       seq = ledger.wait_tok[k] - 16'd1;
      default: seq = 16'($urandom);
    endcase
    send_item(mk(3'($urandom_range(0, 7)), k, $urandom, seq));
  endtask

  // output side: random stalls, independent of out_valid_o
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left  <= idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_mon
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status        = status_o;
      got.token         = token_o;
      got.ack_accepted  = ack_accepted_o;
      got.payload       = payload_o;
      got.ignored_count = ignored_count_o;
      ledger.match_result(got);
    end
  end

  // ends the run if no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= HANG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, HANG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    logic [31:0] d;
    ledger = new();
    ledger.power_on();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty checks, stray acks, exact match, re-arm, timeout, spare codes
    send_item(mk(ACT_CHECK, 2'd0, 32'h0, 16'h0));
    send_item(mk(ACT_ACK, 2'd0, 32'hFFFF_FFFF, 16'h0));
    send_item(mk(ACT_BEGIN, 2'd0, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk(ACT_ARM, 2'd0, 32'h0, 16'h0));
    send_item(mk(ACT_ACK, 2'd0, 32'h1234_5678, 16'hFFFF));
    send_item(mk(ACT_ACK, 2'd0, 32'hFFFF_FFFF, ledger.wait_tok[0]));
    send_item(mk(ACT_ACK, 2'd0, 32'h0, 16'd1));
    send_item(mk(ACT_CHECK, 2'd0, 32'hFFFF_FFFF, 16'h0));
    send_item(mk(ACT_CHECK, 2'd0, 32'hFFFF_FFFF, 16'h0));
    send_item(mk(ACT_ARM, 2'd1, 32'h0, 16'h0));
    send_item(mk(ACT_ACK, 2'd1, 32'h0, ledger.wait_tok[1]));
    send_item(mk(ACT_CHECK, 2'd1, 32'h1, 16'h0));
    send_item(mk(ACT_ARM, 2'd2, 32'h0, 16'h0));
    send_item(mk(ACT_TIMEOUT, 2'd2, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk(ACT_ACK, 2'd2, 32'h5555_AAAA, 16'd1));
    send_item(mk(ACT_ARM, 2'd3, 32'h0, 16'h0));
    send_item(mk(ACT_ARM, 2'd3, 32'h0, 16'h0));
    send_item(mk(ACT_ACK, 2'd3, 32'h0, 16'd1));
    send_item(mk(ACT_ACK, 2'd3, 32'hA5A5_5A5A, 16'd2));
    // re-arm while the ack is still pending wipes the payload
    send_item(mk(ACT_ARM, 2'd3, 32'h0, 16'h0));
    send_item(mk(ACT_CHECK, 2'd3, 32'hA5A5_5A5A, 16'h0));
    send_item(mk(ACT_SPARE_6, 2'd1, $urandom, 16'($urandom)));
    send_item(mk(ACT_SPARE_7, 2'd2, $urandom, 16'($urandom)));
    send_item(mk(ACT_SESSION_RESET, 2'd3, $urandom, 16'($urandom)));
    send_item(mk(ACT_ARM, 2'd0, 32'h0, 16'h0));

    // random: mostly complete exchanges, some noise
    sent = ledger.n_items;
    while (ledger.n_items - sent < RANDOM_ITEMS) begin
      if ((ledger.n_items % 60) < 5) calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) run_exchange(2'($urandom_range(0, NINST - 1)));
      else send_noise();
    end

    // closing sequence on instance 3, then a session reset and a final arm
    calm = 1'b0;
    send_item(mk(ACT_ARM, 2'd3, $urandom, 16'($urandom)));
    d = $urandom;
    send_item(mk(ACT_ACK, 2'd3, d, 16'hFFFF));
    send_item(mk(ACT_CHECK, 2'd3, d, 16'($urandom)));
    send_item(mk(ACT_ARM, 2'd3, $urandom, 16'($urandom)));
    send_item(mk(ACT_TIMEOUT, 2'd3, $urandom, 16'($urandom)));
    send_item(mk(ACT_SESSION_RESET, 2'd0, $urandom, 16'($urandom)));
    send_item(mk(ACT_ARM, 2'd3, $urandom, 16'($urandom)));
    in_valid_i <= 1'b0;

    while (ledger.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d transactions, %0d results checked, with random stalls on both sides.",
             ledger.n_items, ledger.n_checked);
    $display("Status mix: ok %0d, mismatch %0d, timeout %0d, no-ack %0d, ignored %0d",
             ledger.status_hits[ST_OK], ledger.status_hits[ST_MISMATCH],
             ledger.status_hits[ST_TIMEOUT], ledger.status_hits[ST_NO_ACK],
             ledger.status_hits[ST_IGNORED]);
    if (ledger.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
